>>> rtl/ahe_pkg.sv
package ahe_pkg;

    // request codes
    localparam logic [1:0] MODE_VALUE  = 2'd0;
    localparam logic [1:0] MODE_DERIV1 = 2'd1;
    localparam logic [1:0] MODE_DERIV2 = 2'd2;
    localparam logic [1:0] MODE_KERNEL = 2'd3;

    localparam logic [30:0] SQRT_2_PI_Q31   = 31'd1713444047;
    localparam logic [29:0] TURN_SCALE_HI   = 30'd683565275;
    localparam logic [31:0] TURN_SCALE_LO   = 32'd2475754870;
    localparam logic [33:0] CORDIC_INV_GAIN = 34'd652032874;
    localparam logic [63:0] COEF_LIMIT      = 64'h3FFF_FFFF_FFFF_FFFF;
    // upper part of the 2^61 dividend, below any valid root
    localparam logic [30:0] DIV_SEED        = 31'h2000_0000;

    localparam logic [31:0] PHASE_EIGHTH  = 32'h2000_0000;
    localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;
    localparam logic [31:0] PHASE_HALF    = 32'h8000_0000;

    localparam int SQ_BITS  = 31;
    localparam int DIV_BITS = 32;

    typedef struct packed {
        logic        valid;
        logic [1:0]  mode;
        logic        zero;
        logic        flip;
        logic [5:0]  h;
        logic [33:0] z;
    } ahe_ctl_t;

    typedef struct packed {
        logic [31:0] real_value;
        logic [31:0] imag_value;
        logic        overflowed;
        logic        bad_argument;
    } ahe_res_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        unique case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // mantissa * 2^(sh-30) as non-negative Q30, truncated, clamped
    function automatic logic [63:0] to_coef(input logic [33:0] mant,
                                            input logic signed [9:0] sh);
        logic [95:0] wide;
        logic [9:0]  nsh;
        logic [63:0] res;
        wide = '0;
        nsh  = '0;
        res  = '0;
        if (mant == '0) begin
            res = '0;
        end else if (sh >= 10'sd0) begin
            if (sh >= 10'sd62) begin
                res = COEF_LIMIT;
            end else begin
                wide = {62'b0, mant} << sh[5:0];
                if (|wide[95:62]) res = COEF_LIMIT;
                else res = {2'b0, wide[61:0]};
            end
        end else begin
            nsh = 10'(-sh);
            if (nsh >= 10'd64) res = '0;
            else res = {30'b0, mant} >> nsh[5:0];
        end
        return res;
    endfunction

    // clamp to 32 bits; bit 32 flags saturation
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -66'sd2147483648) r = {1'b1, 32'h8000_0000};
        else r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

>>> rtl/asymptotic_hankel_evaluator.sv
// Throughput: one transaction per cycle while the output queue is not full; a full
// queue stalls the whole pipeline and holds s_ready low.
// Depth is set by the square root and the reciprocal, one bit per stage each,
// and by the rotation, one stage per CORDIC step; a two-entry output queue holds results.
// Reset (aresetn low, synchronous) empties the pipeline and the queue; no clearing pass.
module asymptotic_hankel_evaluator import ahe_pkg::*; #(
    parameter int ARG_FRAC_BITS   = 20,
    parameter int OUT_FRAC_BITS   = 16,
    parameter int ROTATION_STAGES = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_arg,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_real_value,
    output logic [31:0] m_imag_value,
    output logic        m_overflowed,
    output logic        m_bad_argument
);

    localparam int R         = ROTATION_STAGES;
    localparam int ST_ROOT   = SQ_BITS;
    localparam int ST_U      = ST_ROOT + DIV_BITS;
    localparam int ST_MG1    = ST_U + 1;
    localparam int ST_MG2    = ST_U + 2;
    localparam int ST_MG3    = ST_U + 3;
    localparam int ST_COEF   = ST_U + 4;
    localparam int ST_TRIG   = ST_COEF + R;
    localparam int ST_PP     = ST_TRIG + 1;
    localparam int ST_LAST   = ST_PP + 1;
    localparam int NST       = ST_LAST + 1;
    localparam int PQ_SHIFT  = 28 - OUT_FRAC_BITS;
    localparam bit AFB_ODD   = (ARG_FRAC_BITS % 2) == 1;
    localparam logic [1:0] Q_FULL = 2'd2;

    logic       adv;
    ahe_ctl_t   ctl_reg  [0:NST-1];
    ahe_ctl_t   ctl_next [0:NST-1];

    // ---------------- front: normalize, phase products ----------------
    logic [4:0]  msb_idx;
    logic [5:0]  e_raw, e_norm;
    logic [6:0]  e_sum;
    logic [5:0]  h_calc;
    logic [61:0] m_norm;
    logic [61:0] f_m_reg, f_phh_reg;
    logic [63:0] f_phl_reg;

    always_comb begin
        msb_idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (s_arg[i]) msb_idx = 5'(i);
        end
        e_raw  = 6'd60 - {1'b0, msb_idx};
        e_norm = e_raw + {5'b0, e_raw[0] ^ AFB_ODD};
        e_sum  = {1'b0, e_norm} + 7'(ARG_FRAC_BITS);
        h_calc = e_sum[6:1];
        m_norm = {30'b0, s_arg} << e_norm;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_m_reg   <= m_norm;
            f_phh_reg <= 62'(s_arg) * 62'(TURN_SCALE_HI);
            f_phl_reg <= 64'(s_arg) * 64'(TURN_SCALE_LO);
        end
    end

    // phase in turns, less an eighth turn, folded into the right half plane
    logic [62:0] ph_sum;
    logic [31:0] ph_raw, ph_off, ph_test, ph_rot;
    logic        ph_flip;

    always_comb begin
        ph_sum  = {1'b0, f_phh_reg} + {31'b0, f_phl_reg[63:32]};
        ph_raw  = 32'(ph_sum >> ARG_FRAC_BITS);
        ph_off  = ph_raw - PHASE_EIGHTH;
        ph_test = ph_off + PHASE_QUARTER;
        ph_flip = ph_test[31];
        ph_rot  = ph_flip ? ph_off + PHASE_HALF : ph_off;
    end

    always_comb begin
        ctl_next[0]       = '0;
        ctl_next[0].valid = s_valid;
        ctl_next[0].mode  = s_req_type;
        ctl_next[0].zero  = (s_arg == '0);
        ctl_next[0].h     = h_calc;
        for (int i = 1; i < NST; i++) begin
            ctl_next[i] = ctl_reg[i-1];
        end
        ctl_next[1].flip = ph_flip;
        ctl_next[1].z    = {{2{ph_rot[31]}}, ph_rot};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NST; i++) ctl_reg[i] <= '0;
        end else if (adv) begin
            for (int i = 0; i < NST; i++) ctl_reg[i] <= ctl_next[i];
        end
    end

    // ---------------- square root, one bit per stage ----------------
    logic [62:0] sq_rem_reg  [1:SQ_BITS-1];
    logic [30:0] sq_root_reg [1:SQ_BITS];

    for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
        localparam int B = SQ_BITS - 1 - j;
        logic [62:0] rem_in, trial;
        logic [30:0] root_in;
        logic        ge;
        if (j == 0) begin : g_first
            assign rem_in  = {1'b0, f_m_reg};
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = sq_rem_reg[j];
            assign root_in = sq_root_reg[j];
        end
        assign trial = (63'(root_in) << (B + 1)) + (63'(1) << (2 * B));
        assign ge    = rem_in >= trial;
        always_ff @(posedge aclk) begin
            if (adv) sq_root_reg[j+1] <= root_in | (31'(ge) << B);
        end
        if (j < SQ_BITS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (adv) sq_rem_reg[j+1] <= ge ? rem_in - trial : rem_in;
            end
        end
    end

    // ---------------- reciprocal 2^61 / root, one bit per stage ----------------
    logic [30:0] dv_rem_reg [0:DIV_BITS-2];
    logic [30:0] dv_s_reg   [0:DIV_BITS-2];
    logic [31:0] dv_q_reg   [0:DIV_BITS-1];

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        logic [30:0] rem_in, s_in;
        logic [31:0] q_in, r2, diff;
        logic        ge;
        if (j == 0) begin : g_first
            assign rem_in = DIV_SEED;
            assign s_in   = sq_root_reg[SQ_BITS];
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = dv_rem_reg[j-1];
            assign s_in   = dv_s_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
        end
        assign r2   = {rem_in, 1'b0};
        assign ge   = r2 >= {1'b0, s_in};
        assign diff = r2 - {1'b0, s_in};
        always_ff @(posedge aclk) begin
            if (adv) dv_q_reg[j] <= {q_in[30:0], ge};
        end
        if (j < DIV_BITS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_rem_reg[j] <= ge ? diff[30:0] : r2[30:0];
                    dv_s_reg[j]   <= s_in;
                end
            end
        end
    end

    // ---------------- magnitude products ----------------
    logic [31:0] u_val;
    logic [62:0] k_prod;
    logic [63:0] uu_prod, m3_prod, m5_prod;
    logic [31:0] mg1_m1_reg, mg1_w_reg;
    logic [31:0] mg2_m1_reg, mg2_w_reg, mg2_m3_reg;
    logic [31:0] mg3_m1_reg, mg3_m3_reg, mg3_m5_reg;

    assign u_val   = dv_q_reg[DIV_BITS-1];
    assign k_prod  = 63'(SQRT_2_PI_Q31) * 63'(u_val);
    assign uu_prod = 64'(u_val) * 64'(u_val);
    assign m3_prod = 64'(mg1_m1_reg) * 64'(mg1_w_reg);
    assign m5_prod = 64'(mg2_m3_reg) * 64'(mg2_w_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            mg1_m1_reg <= k_prod[62:31];
            mg1_w_reg  <= uu_prod[62:31];
            mg2_m1_reg <= mg1_m1_reg;
            mg2_w_reg  <= mg1_w_reg;
            mg2_m3_reg <= m3_prod[62:31];
            mg3_m1_reg <= mg2_m1_reg;
            mg3_m3_reg <= mg2_m3_reg;
            mg3_m5_reg <= m5_prod[62:31];
        end
    end

    // ---------------- coefficients ----------------
    logic signed [9:0] hs, sh1, sh3, sh5;
    logic [33:0] m5x3;
    logic [63:0] a1, a3, a5, aq, cr_calc, ci_calc;
    logic [63:0] cf_r_reg [0:R];
    logic [63:0] cf_i_reg [0:R];

    always_comb begin
        hs   = signed'({4'b0, ctl_reg[ST_MG3].h});
        sh1  = hs - 10'sd31;
        sh3  = 10'sd3 * hs - 10'sd91;
        sh5  = 10'sd5 * hs - 10'sd153;
        m5x3 = {2'b0, mg3_m5_reg} + {1'b0, mg3_m5_reg, 1'b0};
        a1   = to_coef({2'b0, mg3_m1_reg}, sh1);
        a3   = to_coef({2'b0, mg3_m3_reg},
                       (ctl_reg[ST_MG3].mode == MODE_DERIV1) ? sh3 - 10'sd1 : sh3);
        a5   = to_coef(m5x3, sh5);
        aq   = to_coef({2'b0, mg3_m1_reg}, sh1 - 10'sd2);
        unique case (ctl_reg[ST_MG3].mode)
            MODE_VALUE: begin
                cr_calc = a1;
                ci_calc = '0;
            end
            MODE_DERIV1: begin
                cr_calc = -a3;
                ci_calc = a1;
            end
            MODE_DERIV2: begin
                cr_calc = a5 - a1;
                ci_calc = -a3;
            end
            default: begin
                cr_calc = '0;
                ci_calc = -aq;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cf_r_reg[0] <= cr_calc;
            cf_i_reg[0] <= ci_calc;
        end
    end

    // ---------------- CORDIC rotation, one step per stage ----------------
    logic signed [33:0] cx_reg [0:R-1];
    logic signed [33:0] cy_reg [0:R-1];
    logic signed [33:0] cz_reg [0:R-2];

    for (genvar i = 0; i < R; i++) begin : g_rot
        localparam int I = i;
        logic signed [33:0] x_in, y_in, z_in, dx, dy, at;
        if (i == 0) begin : g_first
            assign x_in = signed'(CORDIC_INV_GAIN);
            assign y_in = '0;
            assign z_in = signed'(ctl_reg[ST_COEF].z);
        end else begin : g_next
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign z_in = cz_reg[i-1];
        end
        assign dx = y_in >>> I;
        assign dy = x_in >>> I;
        assign at = signed'({2'b0, atan_turn(I)});
        always_ff @(posedge aclk) begin
            if (adv) begin
                cf_r_reg[i+1] <= cf_r_reg[i];
                cf_i_reg[i+1] <= cf_i_reg[i];
                if (!z_in[33]) begin
                    cx_reg[i] <= x_in - dx;
                    cy_reg[i] <= y_in + dy;
                end else begin
                    cx_reg[i] <= x_in + dx;
                    cy_reg[i] <= y_in - dy;
                end
            end
        end
        if (i < R - 1) begin : g_z
            always_ff @(posedge aclk) begin
                if (adv) cz_reg[i] <= z_in[33] ? z_in + at : z_in - at;
            end
        end
    end

    // ---------------- coefficient x trig, split partial products ----------------
    // order: cr*cx, ci*cy, cr*cy, ci*cx
    logic [63:0] pp_c [0:3];
    logic [33:0] pp_t [0:3];
    logic [63:0] pp_cm [0:3];
    logic [33:0] pp_tm [0:3];
    logic [62:0] pp_hi_reg [0:3];
    logic [64:0] pp_lo_reg [0:3];
    logic        pp_neg_reg [0:3];

    always_comb begin
        pp_c[0] = cf_r_reg[R];
        pp_c[1] = cf_i_reg[R];
        pp_c[2] = cf_r_reg[R];
        pp_c[3] = cf_i_reg[R];
        pp_t[0] = cx_reg[R-1];
        pp_t[1] = cy_reg[R-1];
        pp_t[2] = cy_reg[R-1];
        pp_t[3] = cx_reg[R-1];
        for (int p = 0; p < 4; p++) begin
            pp_cm[p] = pp_c[p][63] ? -pp_c[p] : pp_c[p];
            pp_tm[p] = pp_t[p][33] ? -pp_t[p] : pp_t[p];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int p = 0; p < 4; p++) begin
                pp_hi_reg[p]  <= 63'(pp_cm[p][61:32]) * 63'(pp_tm[p][32:0]);
                pp_lo_reg[p]  <= 65'(pp_cm[p][31:0]) * 65'(pp_tm[p][32:0]);
                // a half-turn fold negates both trig values
                pp_neg_reg[p] <= pp_c[p][63] ^ pp_t[p][33] ^ ctl_reg[ST_TRIG].flip;
            end
        end
    end

    logic [63:0] pq_sum [0:3];
    logic [63:0] pq_mag [0:3];
    logic signed [64:0] pr_reg [0:3];

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            pq_sum[p] = {1'b0, pp_hi_reg[p]} + {31'b0, pp_lo_reg[p][64:32]};
            pq_mag[p] = pq_sum[p] >> PQ_SHIFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int p = 0; p < 4; p++) begin
                pr_reg[p] <= pp_neg_reg[p] ? -signed'({1'b0, pq_mag[p]})
                                           : signed'({1'b0, pq_mag[p]});
            end
        end
    end

    // ---------------- combine, saturate, output queue ----------------
    logic signed [65:0] fin_re, fin_im;
    logic [32:0] sat_re, sat_im;
    ahe_res_t    res_new, head_reg, skid_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    always_comb begin
        fin_re = 66'(pr_reg[0]) - 66'(pr_reg[1]);
        fin_im = 66'(pr_reg[2]) + 66'(pr_reg[3]);
        sat_re = sat32(fin_re);
        sat_im = sat32(fin_im);
        if (ctl_reg[ST_LAST].zero) begin
            res_new.real_value   = '0;
            res_new.imag_value   = '0;
            res_new.overflowed   = 1'b0;
            res_new.bad_argument = 1'b1;
        end else begin
            res_new.real_value   = sat_re[31:0];
            res_new.imag_value   = sat_im[31:0];
            res_new.overflowed   = sat_re[32] | sat_im[32];
            res_new.bad_argument = 1'b0;
        end
    end

    assign adv     = (cnt_reg != Q_FULL);
    assign s_ready = adv;
    assign push    = adv && ctl_reg[ST_LAST].valid;
    assign pop     = (cnt_reg != 2'd0) && m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (!push && pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && cnt_reg == Q_FULL) begin
            head_reg <= skid_reg;
        end else if (push && (cnt_reg == 2'd0 || pop)) begin
            head_reg <= res_new;
        end
        // hold the second result behind the one on offer
        if (push && !pop && cnt_reg == 2'd1) begin
            skid_reg <= res_new;
        end
    end

    assign m_valid        = (cnt_reg != 2'd0);
    assign m_real_value   = head_reg.real_value;
    assign m_imag_value   = head_reg.imag_value;
    assign m_overflowed   = head_reg.overflowed;
    assign m_bad_argument = head_reg.bad_argument;

    // ---------------- assertions ----------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg[ST_ROOT].valid && !ctl_reg[ST_ROOT].zero |-> sq_root_reg[SQ_BITS][30])
        else $error("normalized root below 2^30");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_argument |->
            m_real_value == '0 && m_imag_value == '0 && !m_overflowed)
        else $error("zero argument with nonzero result");

    a_ovf_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflowed |->
            (m_real_value == 32'h7FFF_FFFF || m_real_value == 32'h8000_0000 ||
             m_imag_value == 32'h7FFF_FFFF || m_imag_value == 32'h8000_0000))
        else $error("overflow flag without saturated part");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top import ahe_pkg::*; ();

    localparam int ARG_FRAC    = 20;
    localparam int OUT_FRAC    = 16;
    localparam int ROT_STAGES  = 24;
    localparam int PROD_SHIFT  = 60 - OUT_FRAC;
    localparam int RAND_ITEMS  = 1880;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 200;
    localparam int IDLE_LIMIT  = 20000;
    localparam longint COEF_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

    localparam ahe_res_t ZERO_ARG_RES = '{32'd0, 32'd0, 1'b0, 1'b1};

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] arg;
        logic        typed;
    } stim_row_t;

    // zero arguments carry a typed-in answer; the rest go through the predictor
    stim_row_t stim_table [22] = '{
        '{MODE_VALUE,  32'd0, 1'b1}, '{MODE_DERIV1, 32'd0, 1'b1},
        '{MODE_DERIV2, 32'd0, 1'b1}, '{MODE_KERNEL, 32'd0, 1'b1},
        '{MODE_VALUE,  32'd1, 1'b0}, '{MODE_DERIV1, 32'd1, 1'b0},
        '{MODE_DERIV2, 32'd1, 1'b0}, '{MODE_KERNEL, 32'd1, 1'b0},
        '{MODE_VALUE,  32'hFFFF_FFFF, 1'b0}, '{MODE_DERIV1, 32'hFFFF_FFFF, 1'b0},
        '{MODE_DERIV2, 32'hFFFF_FFFF, 1'b0}, '{MODE_KERNEL, 32'hFFFF_FFFF, 1'b0},
        '{MODE_VALUE,  32'h0010_0000, 1'b0}, '{MODE_DERIV1, 32'h0010_0000, 1'b0},
        '{MODE_DERIV2, 32'h0010_0000, 1'b0}, '{MODE_KERNEL, 32'h0010_0000, 1'b0},
        '{MODE_VALUE,  32'h8000_0000, 1'b0}, '{MODE_DERIV2, 32'h0000_0003, 1'b0},
        '{MODE_DERIV1, 32'h0000_0100, 1'b0}, '{MODE_DERIV2, 32'h0000_4000, 1'b0},
        '{MODE_KERNEL, 32'h5555_5555, 1'b0}, '{MODE_VALUE,  32'hAAAA_AAAA, 1'b0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [31:0] s_arg = '0;
    logic        drv_typed = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_real_value;
    logic [31:0] m_imag_value;
    logic        m_overflowed;
    logic        m_bad_argument;

    ahe_res_t hankel_expected [$];
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_saturated = 0;
    int n_zero_arg = 0;
    int idle_cycles = 0;

    asymptotic_hankel_evaluator #(
        .ARG_FRAC_BITS  (ARG_FRAC),
        .OUT_FRAC_BITS  (OUT_FRAC),
        .ROTATION_STAGES(ROT_STAGES)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_arg         (s_arg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_real_value  (m_real_value),
        .m_imag_value  (m_imag_value),
        .m_overflowed  (m_overflowed),
        .m_bad_argument(m_bad_argument)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // mantissa * 2^expo as non-negative Q30, truncated, held at the bound
    function automatic longint q30_coef(longint unsigned mant, int expo);
        int sh;
        sh = expo + 30;
        if (mant == 0) return 0;
        if (sh >= 0) begin
            if (sh >= 62 || mant > (64'(COEF_MAX) >> sh)) return COEF_MAX;
            return longint'(mant << sh);
        end
        if (-sh >= 64) return 0;
        return longint'(mant >> (-sh));
    endfunction

    // coefficient times trig value, truncated toward zero to the output scale
    function automatic longint scale_mul(longint c, longint t);
        logic neg;
        longint unsigned mc, mt, hi, lo, q;
        neg = (c < 0) != (t < 0);
        mc = (c < 0) ? -c : c;
        mt = (t < 0) ? -t : t;
        hi = (mc >> 32) * mt;
        lo = (mc & 64'hFFFF_FFFF) * mt;
        q = (hi + (lo >> 32)) >> (PROD_SHIFT - 32);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp_part(longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic ahe_res_t hankel_predict(logic [1:0] mode, logic [31:0] arg_in);
        longint unsigned a, m, s, u, m1, w, m3, m5, ph, rem, bitv;
        longint cr, ci, cx, cy, z, dx, dy;
        int k, e, h, e1, ew, e3, e5;
        logic flip, sat;
        ahe_res_t r;
        a = arg_in;
        r = '0;
        cr = 0;
        ci = 0;
        sat = 1'b0;
        if (a == 0) return ZERO_ARG_RES;
        k = 0;
        while (k < 31 && (a >> (k + 1)) != 0) k++;
        e = 60 - k;
        if (((e + ARG_FRAC) & 1) != 0) e++;
        h = (e + ARG_FRAC) / 2;
        m = a << e;
        // bitwise integer square root
        rem = m;
        s = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= s + bitv) begin
                rem -= s + bitv;
                s = (s >> 1) + bitv;
            end else begin
                s >>= 1;
            end
            bitv >>= 2;
        end
        u = (64'd1 << 61) / s;
        m1 = (64'(SQRT_2_PI_Q31) * u) >> 31;
        e1 = h - 61;
        w = (u * u) >> 31;
        ew = 2 * (h - 61) + 31;
        m3 = (m1 * w) >> 31;
        e3 = e1 + ew + 31;
        m5 = (m3 * w) >> 31;
        e5 = e3 + ew + 31;
        case (mode)
            MODE_VALUE: cr = q30_coef(m1, e1);
            MODE_DERIV1: begin
                cr = -q30_coef(m3, e3 - 1);
                ci = q30_coef(m1, e1);
            end
            MODE_DERIV2: begin
                cr = q30_coef(3 * m5, e5 - 2) - q30_coef(m1, e1);
                ci = -q30_coef(m3, e3);
            end
            default: ci = -q30_coef(m1, e1 - 2);
        endcase
        ph = ((a * 64'(TURN_SCALE_HI) + ((a * 64'(TURN_SCALE_LO)) >> 32)) >> ARG_FRAC)
             & 64'hFFFF_FFFF;
        ph = (ph - 64'(PHASE_EIGHTH)) & 64'hFFFF_FFFF;
        flip = ph[31:0] + PHASE_QUARTER >= PHASE_HALF;
        if (flip) ph = (ph + 64'(PHASE_HALF)) & 64'hFFFF_FFFF;
        z = longint'(int'(ph[31:0]));
        cx = longint'(CORDIC_INV_GAIN);
        cy = 0;
        for (int i = 0; i < ROT_STAGES; i++) begin
            dx = cy >>> (i & 31);
            dy = cx >>> (i & 31);
            if (z >= 0) begin
                cx -= dx;
                cy += dy;
                z -= longint'(ATAN_TURNS[i & 31]);
            end else begin
                cx += dx;
                cy -= dy;
                z += longint'(ATAN_TURNS[i & 31]);
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        r.real_value = clamp_part(scale_mul(cr, cx) - scale_mul(ci, cy), sat);
        r.imag_value = clamp_part(scale_mul(cr, cy) + scale_mul(ci, cx), sat);
        r.overflowed = sat;
        r.bad_argument = 1'b0;
        return r;
    endfunction

    // mostly back to back, sometimes short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    always @(posedge aclk) begin
        ahe_res_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                hankel_expected.push_back(drv_typed ? ZERO_ARG_RES
                                                    : hankel_predict(s_req_type, s_arg));
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (m_overflowed) n_saturated++;
                if (m_bad_argument) n_zero_arg++;
                if (hankel_expected.size() == 0) begin
                    $error("result with no transaction outstanding");
                    n_errors++;
                end else begin
                    want = hankel_expected.pop_front();
                    if (m_real_value !== want.real_value) begin
                        $error("real_value: expected %h, got %h", want.real_value, m_real_value);
                        n_errors++;
                    end
                    if (m_imag_value !== want.imag_value) begin
                        $error("imag_value: expected %h, got %h", want.imag_value, m_imag_value);
                        n_errors++;
                    end
                    if (m_overflowed !== want.overflowed) begin
                        $error("overflowed: expected %b, got %b", want.overflowed, m_overflowed);
                        n_errors++;
                    end
                    if (m_bad_argument !== want.bad_argument) begin
                        $error("bad_argument: expected %b, got %b",
                               want.bad_argument, m_bad_argument);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("FAIL asymptotic_hankel_evaluator");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off once traffic is flowing
    initial begin
        int g;
        bit long_done;
        long_done = 0;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 20)) @(posedge aclk);
            if (!long_done && n_accepted >= 600) begin
                long_done = 1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_item(logic [1:0] mode, logic [31:0] arg, logic typed);
        int g;
        s_valid <= 1'b1;
        s_req_type <= mode;
        s_arg <= arg;
        drv_typed <= typed;
        do @(posedge aclk); while (!s_ready);
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    initial begin
        logic [31:0] arg;
        int sel;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (stim_table[i])
            send_item(stim_table[i].mode, stim_table[i].arg, stim_table[i].typed);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            sel = $urandom_range(0, 39);
            if (sel == 0) arg = '0;
            else if (sel < 24) arg = $urandom >> $urandom_range(0, 31);
            else arg = $urandom;
            send_item(2'($urandom_range(0, 3)), arg, 1'b0);
            if (n == 1200) begin
                // hold the source until the pipeline has emptied
                s_valid <= 1'b0;
                wait (hankel_expected.size() == 0);
                @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        wait (hankel_expected.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d transactions in all four modes, %0d results checked",
                 n_accepted, n_results);
        $display("%0d saturated results, %0d zero arguments, %0d mismatches",
                 n_saturated, n_zero_arg, n_errors);
        if (n_errors == 0 && hankel_expected.size() == 0)
            $display("PASS asymptotic_hankel_evaluator");
        else
            $display("FAIL asymptotic_hankel_evaluator");
        $finish;
    end

endmodule
